### rtl/jacobi_poisson_stencil_macros.svh
// ----------------------------------------------------------------------------
// Jacobi stencil assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef JACOBI_POISSON_STENCIL_MACROS_SVH
`define JACOBI_POISSON_STENCIL_MACROS_SVH

// same-cycle implication
`define JPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/jps_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi stencil package
// Sizes, register indexes, command codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package jps_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int SIZE_W   = 11;
  localparam int IDX_W    = 3;

  localparam logic [SIZE_W-1:0] MIN_SIZE      = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] MAX_COLS_SIZE = SIZE_W'(MAX_COLS);
  localparam logic [SIZE_W-1:0] MAX_ROWS_SIZE = SIZE_W'(MAX_ROWS);

  typedef enum logic [IDX_W-1:0] {
    REG_GRID_COLS   = 3'd0,
    REG_GRID_ROWS   = 3'd1,
    REG_H_SQUARED   = 3'd2,
    REG_H_STEP      = 3'd3,
    REG_TOL_SQUARED = 3'd4
  } reg_idx_e;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] grid_cols;
    logic [SIZE_W-1:0] grid_rows;
    logic [31:0]       h_squared;
    logic [31:0]       h_step;
    logic [31:0]       tol_squared;
  } cfg_t;

  // one classified item, front to back
  typedef struct packed {
    logic               flush;
    logic               emit;
    logic               interior;
    logic               last;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic signed [31:0] old_value;
    logic signed [31:0] forcing;
  } q_t;

  typedef enum logic [3:0] {
    B_IDLE, B_RD1, B_RD2, B_MUL, B_SUM, B_SQ, B_ACC, B_CV1, B_CV2, B_CMP, B_OUT
  } back_state_t;

endpackage

`default_nettype wire

### rtl/jps_if.sv
// ----------------------------------------------------------------------------
// Jacobi stencil channels
// Grid sample, result and register write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface jps_in_if;
  import jps_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] old_value;
  logic signed [31:0] forcing;
  modport source (output valid, cmd, old_value, forcing, input ready);
  modport sink (input valid, cmd, old_value, forcing, output ready);
endinterface

interface jps_out_if;
  import jps_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_value;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  logic               last;
  logic               converged;
  modport source (output valid, new_value, out_row, out_col, last, converged, input ready);
  modport sink (input valid, new_value, out_row, out_col, last, converged, output ready);
endinterface

interface jps_cfg_if;
  import jps_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [31:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/jacobi_poisson_stencil.sv
// ----------------------------------------------------------------------------
// Jacobi Poisson stencil
// One Jacobi sweep of the 5-point Poisson stencil over a raster-order stream.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                   beat
//   sample   in   cmd, old_value, forcing                   valid & ready
//   result   out  new_value, out_row, out_col, last, conv   valid & ready
//   cfg      in   index (3b), data (32b)                    valid & ready
//
// A sample that emits no result (first row) ends after the line buffer write,
// one that emits adds the error sum and the final flush the convergence check;
// the back end reads the upper and middle buffers twice per item via one port.
// The two-entry queue lets the front take up to two beats while the back
// works or while a result waits for the sink.
// rst is synchronous; it clears position counters, queue, sequencer and the
// error sum. Line buffers are not cleared and need no clearing pass.
// cfg is always ready; write registers only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_poisson_stencil (
  input  wire        clk,
  input  wire        rst,
  jps_in_if.sink     sample,
  jps_out_if.source  result,
  jps_cfg_if.sink    cfg
);
  import jps_pkg::*;

  cfg_t cfg_regs;
  q_t   push_data, pop_data;
  logic push, pop, full, empty;

  assign cfg.ready = 1'b1;

  // register file, reset to the documented defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.grid_cols   <= MIN_SIZE;
      cfg_regs.grid_rows   <= MIN_SIZE;
      cfg_regs.h_squared   <= '0;
      cfg_regs.h_step      <= '0;
      cfg_regs.tol_squared <= '0;
    end else if (cfg.valid) begin
      case (reg_idx_e'(cfg.index))
        REG_GRID_COLS:   cfg_regs.grid_cols   <= cfg.data[SIZE_W-1:0];
        REG_GRID_ROWS:   cfg_regs.grid_rows   <= cfg.data[SIZE_W-1:0];
        REG_H_SQUARED:   cfg_regs.h_squared   <= cfg.data;
        REG_H_STEP:      cfg_regs.h_step      <= cfg.data;
        REG_TOL_SQUARED: cfg_regs.tol_squared <= cfg.data;
        default: ;
      endcase
    end
  end

  // front: position tracking and classification
  jps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .cfg_regs  (cfg_regs),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  jps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  // back: line buffers, arithmetic, result register
  jps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire

### rtl/jps_front.sv
// ----------------------------------------------------------------------------
// Jacobi stencil front end
// Tracks grid position, classifies each beat and pushes work to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module jps_front (
  input  wire             clk,
  input  wire             rst,
  jps_in_if.sink          sample,
  input  jps_pkg::cfg_t   cfg_regs,
  input  wire             full,
  output logic            push,
  output jps_pkg::q_t     push_data
);
  import jps_pkg::*;

  logic [SIZE_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0]  in_col, in_col_next;
  logic [SIZE_W-1:0] cols, rows;
  logic              all_in, row_end, take;

  always_comb begin
    if (cfg_regs.grid_cols < MIN_SIZE) cols = MIN_SIZE;
    else if (cfg_regs.grid_cols > MAX_COLS_SIZE) cols = MAX_COLS_SIZE;
    else cols = cfg_regs.grid_cols;
    if (cfg_regs.grid_rows < MIN_SIZE) rows = MIN_SIZE;
    else if (cfg_regs.grid_rows > MAX_ROWS_SIZE) rows = MAX_ROWS_SIZE;
    else rows = cfg_regs.grid_rows;
  end

  assign all_in       = (in_row >= rows);
  assign row_end      = (({1'b0, in_col} + SIZE_W'(1)) >= cols);
  assign sample.ready = !full;
  assign take         = sample.valid && !full;

  always_comb begin
    push_data           = '0;
    push                = 1'b0;
    in_row_next         = in_row;
    in_col_next         = in_col;
    push_data.col       = in_col;
    push_data.old_value = sample.old_value;
    push_data.forcing   = sample.forcing;
    if (take) begin
      if (sample.cmd == CMD_FLUSH) begin
        if (all_in) begin
          push           = 1'b1;
          push_data.flush = 1'b1;
          push_data.emit = 1'b1;
          push_data.last = row_end;
          push_data.row  = ROW_W'(rows - SIZE_W'(1));
          if (row_end) begin
            in_row_next = '0;
            in_col_next = '0;
          end else begin
            in_col_next = in_col + COL_W'(1);
          end
        end
      end else if (!all_in) begin
        push               = 1'b1;
        push_data.emit     = (in_row != '0);
        push_data.row      = ROW_W'(in_row - SIZE_W'(1));
        push_data.interior = !(in_row == SIZE_W'(1) || in_row >= rows ||
                               in_col == '0 || row_end);
        if (row_end) begin
          in_col_next = '0;
          in_row_next = in_row + SIZE_W'(1);
        end else begin
          in_col_next = in_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0;
      in_col <= '0;
    end else begin
      in_row <= in_row_next;
      in_col <= in_col_next;
    end
  end

endmodule

`default_nettype wire

### rtl/jps_queue.sv
// ----------------------------------------------------------------------------
// Jacobi stencil work queue
// Two-entry FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jacobi_poisson_stencil_macros.svh"

module jps_queue (
  input  wire          clk,
  input  wire          rst,
  input  wire          push,
  input  jps_pkg::q_t  push_data,
  input  wire          pop,
  output jps_pkg::q_t  pop_data,
  output logic         full,
  output logic         empty
);
  import jps_pkg::*;

  q_t         slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `JPS_ASSERT_NOW(a_no_push_full, full, !push, "push into full queue")
  `JPS_ASSERT_NOW(a_no_pop_empty, empty, !pop, "pop from empty queue")
  `JPS_ASSERT_NOW(a_count_range, 1'b1, count != 2'd3, "queue count out of range")

endmodule

`default_nettype wire

### rtl/jps_back.sv
// ----------------------------------------------------------------------------
// Jacobi stencil back end
// Line buffers, stencil arithmetic, error sum, convergence and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jacobi_poisson_stencil_macros.svh"

module jps_back (
  input  wire           clk,
  input  wire           rst,
  input  jps_pkg::cfg_t cfg_regs,
  input  jps_pkg::q_t   pop_data,
  input  wire           empty,
  output logic          pop,
  jps_out_if.source     result
);
  import jps_pkg::*;

  back_state_t state, state_next;
  q_t          cur;

  logic [31:0] row_store_upper  [MAX_COLS];
  logic [31:0] row_store_middle [MAX_COLS];
  logic [31:0] forcing_store    [MAX_COLS];
  logic [COL_W-1:0] addr_u, addr_m;
  logic [31:0] upper_q, middle_q, forc_q;
  logic        mem_wr;

  logic signed [31:0] up, ctr, frc, left, right;
  logic signed [63:0] prod;
  logic signed [31:0] new_v;
  logic signed [33:0] diff;
  logic [63:0]        sq;
  logic [63:0]        error_sum;
  logic [63:0]        hi, lo;
  logic               conv;

  logic signed [33:0] nb;
  logic signed [49:0] s;
  logic signed [47:0] q;
  logic signed [31:0] v_calc;
  logic [33:0]        ad;
  logic [64:0]        acc;
  logic [64:0]        scaled;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mem_wr     = 1'b0;
    addr_u     = cur.col;
    addr_m     = cur.col;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = B_RD1;
        end
      end
      B_RD1: state_next = B_RD2;
      B_RD2: begin
        addr_u     = cur.col - COL_W'(1);
        addr_m     = cur.col + COL_W'(1);
        state_next = B_MUL;
      end
      B_MUL: begin
        mem_wr     = !cur.flush;
        state_next = cur.emit ? B_SUM : B_IDLE;
      end
      B_SUM: state_next = B_SQ;
      B_SQ:  state_next = B_ACC;
      B_ACC: state_next = cur.last ? B_CV1 : B_OUT;
      B_CV1: state_next = B_CV2;
      B_CV2: state_next = B_CMP;
      B_CMP: state_next = B_OUT;
      B_OUT: if (result.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      row_store_upper[cur.col]  <= ctr;
      row_store_middle[cur.col] <= cur.old_value;
      forcing_store[cur.col]    <= cur.forcing;
    end
    upper_q  <= row_store_upper[addr_u];
    middle_q <= row_store_middle[addr_m];
    forc_q   <= forcing_store[cur.col];
  end

  // stencil: floor(h2*f) in Q16.16, add neighbours, round /4, saturate
  always_comb begin
    nb = 34'(up) + 34'(cur.old_value) + 34'(left) + 34'(right);
    s  = 50'(nb) + 50'(prod >>> 16);
    q  = 48'((s + 50'sd2) >>> 2);
    if (q > 48'sd2147483647) v_calc = 32'sh7fffffff;
    else if (q < -48'sd2147483648) v_calc = 32'sh80000000;
    else v_calc = q[31:0];
    ad     = diff[33] ? 34'(-diff) : 34'(diff);
    acc    = {1'b0, error_sum} + {1'b0, sq};
    scaled = {1'b0, hi} + {33'b0, lo[63:32]};
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= pop_data;
    case (state)
      B_RD2: begin
        up  <= upper_q;
        ctr <= middle_q;
        frc <= forc_q;
      end
      B_MUL: begin
        left  <= upper_q;
        right <= middle_q;
        prod  <= 64'($signed({1'b0, cfg_regs.h_squared}) * frc);
      end
      B_SUM: begin
        new_v <= (cur.interior && !cur.flush) ? v_calc : ctr;
        diff  <= (cur.interior && !cur.flush) ? 34'(v_calc) - 34'(ctr) : '0;
      end
      B_SQ:  sq <= (ad[33:32] != 2'b00) ? '1 : ad[31:0] * ad[31:0];
      B_CV1: hi <= error_sum[63:32] * cfg_regs.h_step;
      B_CV2: lo <= error_sum[31:0] * cfg_regs.h_step;
      B_CMP: conv <= (scaled < {33'b0, cfg_regs.tol_squared});
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
    end else if (state == B_ACC) begin
      error_sum <= acc[64] ? '1 : acc[63:0];
    end else if (state == B_OUT && result.ready && cur.last) begin
      error_sum <= '0;
    end
  end

  assign result.valid     = (state == B_OUT);
  assign result.new_value = new_v;
  assign result.out_row   = cur.row;
  assign result.out_col   = cur.col;
  assign result.last      = cur.last;
  assign result.converged = cur.last & conv;

  `JPS_ASSERT_NOW(a_pop_idle, pop, state == B_IDLE, "pop outside idle")
  `JPS_ASSERT_NOW(a_wr_sample, mem_wr, !cur.flush, "line buffer write on flush")
  `JPS_ASSERT_NEXT(a_out_hold, result.valid && !result.ready, result.valid,
                   "result dropped while stalled")
  `JPS_ASSERT_NOW(a_last_flush, result.valid && result.last, cur.flush,
                  "last on a grid sample result")

endmodule

`default_nettype wire

### verif/jacobi_poisson_stencil_test.sv
// ----------------------------------------------------------------------------
// Jacobi Poisson stencil testbench
// Streams grid sweeps into the stencil under random stalls on both sides and
// checks every result beat against a cycle-free predictor of the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_poisson_stencil_test;
  import jps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat on any channel
  localparam int SETTLE_CYCLES  = 16;    // covers the longest item, the final flush

  // expected result of one point
  typedef struct {
    logic signed [31:0] new_value;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic               last;
    logic               converged;
  } point_t;

  // directed stimulus row; typed rows carry the new value read off by hand
  typedef struct {
    logic        cmd;
    logic [31:0] old_value;
    logic [31:0] forcing;
    bit          typed;
    logic [31:0] typed_value;
  } stim_row_t;

  logic clk;
  logic rst;

  jps_in_if  sample_ch ();
  jps_out_if result_ch ();
  jps_cfg_if cfg_ch ();

  jacobi_poisson_stencil DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the line buffers, counters and registers
  // --------------------------------------------------------------------------
  logic [31:0]     upper_row   [MAX_COLS];
  logic [31:0]     middle_row  [MAX_COLS];
  logic [31:0]     forcing_row [MAX_COLS];
  int unsigned     row_in;
  int unsigned     col_in;
  longint unsigned err_acc;
  logic [10:0]     cols_reg;
  logic [10:0]     rows_reg;
  logic [31:0]     hsq_reg;
  logic [31:0]     hstep_reg;
  logic [31:0]     tol_reg;

  point_t pending_points[$];

  int  mismatches;
  bit  failed;
  int  idle_cycles;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  items_sent;

  // typed expectation travels with the beat, so it is sampled at acceptance
  logic        drv_typed;
  logic [31:0] drv_typed_value;

  function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned mx);
    if (v < 3) return 3;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic longint signed floor_q(longint signed x, int s);
    return x >>> s;
  endfunction

  // saturating sum of squared changes, unsigned Q32.32
  task automatic add_change(longint signed nv, longint signed ov);
    longint signed   d;
    longint unsigned ad;
    longint unsigned sq;
    d  = nv - ov;
    ad = (d < 0) ? longint'(-d) : longint'(d);
    sq = (ad >= 64'h1_0000_0000) ? '1 : ad * ad;
    if (err_acc > ~sq) err_acc = '1;
    else err_acc = err_acc + sq;
  endtask

  // exact Q48.48 compare: err_acc * h_step < tol_squared << 32
  function automatic logic sweep_converged();
    logic [127:0] p;
    p = 128'(err_acc) * 128'(hstep_reg);
    return p < (128'(tol_reg) << 32);
  endfunction

  // one accepted item through the stencil; queues at most one result
  task automatic stencil_step(logic cmd, logic [31:0] oldv, logic [31:0] frc,
                              bit typed, logic [31:0] typed_value);
    int unsigned   cols;
    int unsigned   rows;
    int unsigned   c;
    int unsigned   er;
    bit            all_in;
    longint signed ctr;
    longint signed nb;
    longint signed prod;
    longint signed s;
    longint signed v;
    point_t        p;
    cols   = clamp_dim(cols_reg, MAX_COLS);
    rows   = clamp_dim(rows_reg, MAX_ROWS);
    c      = col_in;
    all_in = (row_in >= rows);
    if (cmd == CMD_FLUSH) begin
      if (!all_in) return;  // flush before the grid is complete
      v = longint'($signed(middle_row[c]));
      add_change(v, v);
      p.new_value = v[31:0];
      p.out_row   = ROW_W'(rows - 1);
      p.out_col   = COL_W'(c);
      p.last      = (c + 1 >= cols);
      p.converged = p.last ? sweep_converged() : 1'b0;
      if (typed) p.new_value = typed_value;
      pending_points.push_back(p);
      if (p.last) begin
        row_in  = 0;
        col_in  = 0;
        err_acc = 0;
      end else begin
        col_in = c + 1;
      end
    end else begin
      if (all_in) return;  // sample while the last row is still pending
      if (row_in >= 1) begin
        er  = row_in - 1;
        ctr = longint'($signed(middle_row[c]));
        if (er == 0 || er + 1 >= rows || c == 0 || c + 1 >= cols) begin
          v = ctr;  // Dirichlet edge
        end else begin
          nb = longint'($signed(upper_row[c])) + longint'($signed(oldv))
             + longint'($signed(upper_row[c-1])) + longint'($signed(middle_row[c+1]));
          prod = longint'(hsq_reg) * longint'($signed(forcing_row[c]));
          s    = nb + floor_q(prod, 16);
          v    = floor_q(s + 2, 2);
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
        end
        add_change(v, ctr);
        p.new_value = v[31:0];
        p.out_row   = ROW_W'(er);
        p.out_col   = COL_W'(c);
        p.last      = 1'b0;
        p.converged = 1'b0;
        if (typed) p.new_value = typed_value;
        pending_points.push_back(p);
      end
      upper_row[c]   = middle_row[c];
      middle_row[c]  = oldv;
      forcing_row[c] = frc;
      if (c + 1 >= cols) begin
        col_in = 0;
        row_in = row_in + 1;
      end else begin
        col_in = c + 1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset, receiver stalls
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on input beats, checks output beats, runs the watchdog.
  // Everything is sampled at the edge; drivers only use nonblocking updates.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    point_t want;
    bit     beat;
    beat = 1'b0;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        beat = 1'b1;
        case (reg_idx_e'(cfg_ch.index))
          REG_GRID_COLS:   cols_reg  = cfg_ch.data[10:0];
          REG_GRID_ROWS:   rows_reg  = cfg_ch.data[10:0];
          REG_H_SQUARED:   hsq_reg   = cfg_ch.data;
          REG_H_STEP:      hstep_reg = cfg_ch.data;
          REG_TOL_SQUARED: tol_reg   = cfg_ch.data;
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        beat = 1'b1;
        stencil_step(sample_ch.cmd, sample_ch.old_value, sample_ch.forcing,
                     drv_typed, drv_typed_value);
      end
      if (result_ch.valid && result_ch.ready) begin
        beat = 1'b1;
        if (pending_points.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: value %h row %0d col %0d",
                     result_ch.new_value, result_ch.out_row, result_ch.out_col);
        end else begin
          want = pending_points.pop_front();
          if (result_ch.new_value !== want.new_value || result_ch.out_row !== want.out_row ||
              result_ch.out_col !== want.out_col || result_ch.last !== want.last ||
              result_ch.converged !== want.converged) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp val %h r %0d c %0d last %b conv %b, got %h r %0d c %0d last %b conv %b",
                       want.new_value, want.out_row, want.out_col, want.last, want.converged,
                       result_ch.new_value, result_ch.out_row, result_ch.out_col,
                       result_ch.last, result_ch.converged);
          end
        end
      end
    end
    idle_cycles = beat ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL jacobi_poisson_stencil");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // one beat on the sample channel; valid stays high into the next beat
  // unless the sender decides to idle first
  task automatic send_beat(logic cmd, logic [31:0] oldv, logic [31:0] frc,
                           bit typed = 1'b0, logic [31:0] typed_value = '0);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.cmd       <= cmd;
    sample_ch.old_value <= oldv;
    sample_ch.forcing   <= frc;
    drv_typed           <= typed;
    drv_typed_value     <= typed_value;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // sender holds off until every expected result is back, then lets the
  // back end settle (covers items that produce nothing)
  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic write_all(logic [10:0] cols, logic [10:0] rows, logic [31:0] hsq,
                           logic [31:0] hstep, logic [31:0] tol);
    write_reg(REG_GRID_COLS, 32'(cols));
    write_reg(REG_GRID_ROWS, 32'(rows));
    write_reg(REG_H_SQUARED, hsq);
    write_reg(REG_H_STEP, hstep);
    write_reg(REG_TOL_SQUARED, tol);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] grid_value(int mode, logic [31:0] level);
    case (mode)
      0:       return $urandom();
      1:       return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      default: return level;
    endcase
  endfunction

  // one full sweep at the current sizes, with ignored items mixed in.
  // mode 0: full-range noise, 1: small values, 2: flat grid, converged unless tol_squared is 0
  task automatic run_sweep(int mode);
    int unsigned cols;
    int unsigned rows;
    logic [31:0] level;
    cols  = clamp_dim(cols_reg, MAX_COLS);
    rows  = clamp_dim(rows_reg, MAX_ROWS);
    level = $urandom();
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < cols; c++) begin
        if ($urandom_range(99) < 3)
          send_beat(CMD_FLUSH, $urandom(), $urandom());  // early flush
        send_beat(CMD_SAMPLE, grid_value(mode, level),
                  (mode == 2) ? 32'h0 : grid_value(mode, level));
      end
    end
    if ($urandom_range(9) == 0)
      send_beat(CMD_SAMPLE, $urandom(), $urandom());  // past the end of the grid
    for (int unsigned c = 0; c < cols; c++)
      send_beat(CMD_FLUSH, $urandom(), $urandom());
  endtask

  task automatic random_phase(int send_pct, int recv_pct, int target);
    logic [31:0] hsq;
    logic [31:0] hstep;
    logic [31:0] tol;
    int          start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = items_sent;
    while (items_sent - start < target) begin
      case ($urandom_range(3))
        0:       hsq = 32'h0;
        1:       hsq = 32'hFFFF_FFFF;
        2:       hsq = 32'h0001_0000;
        default: hsq = $urandom();
      endcase
      case ($urandom_range(3))
        0:       hstep = 32'h0;
        1:       hstep = 32'h0000_0100;
        2:       hstep = 32'hFFFF_FFFF;
        default: hstep = $urandom();
      endcase
      case ($urandom_range(2))
        0:       tol = 32'h0;
        1:       tol = 32'hFFFF_FFFF;
        default: tol = $urandom();
      endcase
      write_all(11'($urandom_range(0, 8)), 11'($urandom_range(0, 6)), hsq, hstep, tol);
      run_sweep($urandom_range(2));
      drain();
    end
  endtask

  // directed 3x3 sweeps; the default size after reset is 3x3
  stim_row_t directed [26];

  initial begin
    // plain 3x3 with h_squared 0: only (1,1) is interior
    directed[0]  = '{CMD_FLUSH,  32'h0,         32'h0,         1'b0, 32'h0};
    directed[1]  = '{CMD_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0};
    directed[2]  = '{CMD_SAMPLE, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0};
    directed[3]  = '{CMD_SAMPLE, 32'h0,         32'hFFFF_FFFF, 1'b0, 32'h0};
    directed[4]  = '{CMD_SAMPLE, 32'h1,         32'h0,         1'b1, 32'h7FFF_FFFF};
    directed[5]  = '{CMD_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000};
    directed[6]  = '{CMD_SAMPLE, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'h0};
    directed[7]  = '{CMD_SAMPLE, 32'h8000_0000, 32'h1,         1'b1, 32'h1};
    directed[8]  = '{CMD_SAMPLE, 32'h7FFF_FFFF, 32'h0,         1'b0, 32'h0};
    directed[9]  = '{CMD_SAMPLE, 32'h1234_5678, 32'h0,         1'b1, 32'hFFFF_FFFF};
    directed[10] = '{CMD_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0};
    directed[11] = '{CMD_FLUSH,  32'h0,         32'h0,         1'b1, 32'h8000_0000};
    directed[12] = '{CMD_FLUSH,  32'h0,         32'h0,         1'b1, 32'h7FFF_FFFF};
    directed[13] = '{CMD_FLUSH,  32'h0,         32'h0,         1'b1, 32'h1234_5678};
    // full-scale h_squared and forcing: the interior saturates
    for (int i = 14; i < 23; i++)
      directed[i] = '{CMD_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0};
    for (int i = 23; i < 26; i++)
      directed[i] = '{CMD_FLUSH, 32'h0, 32'h0, 1'b0, 32'h0};
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sample_ch.valid     = 1'b0;
    sample_ch.cmd       = CMD_SAMPLE;
    sample_ch.old_value = '0;
    sample_ch.forcing   = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_GRID_COLS;
    cfg_ch.data         = '0;
    result_ch.ready     = 1'b0;
    drv_typed           = 1'b0;
    drv_typed_value     = '0;
    send_idle_pct       = 0;
    recv_idle_pct       = 0;
    mismatches          = 0;
    failed              = 1'b0;
    idle_cycles         = 0;
    items_sent          = 0;

    // predictor reset state
    foreach (upper_row[i]) begin
      upper_row[i]   = '0;
      middle_row[i]  = '0;
      forcing_row[i] = '0;
    end
    row_in    = 0;
    col_in    = 0;
    err_acc   = 0;
    cols_reg  = 11'd3;
    rows_reg  = 11'd3;
    hsq_reg   = '0;
    hstep_reg = '0;
    tol_reg   = '0;

    @(posedge clk);
    while (rst) @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 54;
    for (int i = 0; i < 14; i++)
      send_beat(directed[i].cmd, directed[i].old_value, directed[i].forcing,
                directed[i].typed, directed[i].typed_value);
    drain();
    write_all(11'd3, 11'd3, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    for (int i = 14; i < 26; i++)
      send_beat(directed[i].cmd, directed[i].old_value, directed[i].forcing,
                directed[i].typed, directed[i].typed_value);
    drain();

    random_phase(12, 54, 400);
    random_phase(54, 12, 400);
    random_phase(0, 0, 400);

    // size extremes: sizes below the minimum clamp to 3
    write_all(11'd0, 11'd1, 32'h0001_0000, 32'h0000_0010, 32'hFFFF_FFFF);
    run_sweep(1);
    drain();
    write_all(11'd1024, 11'd1024, 32'h0, 32'h0, 32'h0);
    write_all(11'd4, 11'd4, 32'h0, 32'h0, 32'h1);
    run_sweep(2);
    drain();

    if (!failed)
      $display("PASS jacobi_poisson_stencil");
    else
      $display("FAIL jacobi_poisson_stencil");
    $finish;
  end

endmodule

`default_nettype wire
